@@ hdl/fit_policy_block_allocator_macros.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge of clk outside reset.
`define FPBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Overlapped implication checked on every rising edge of clk outside reset.
`define FPBA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every rising edge of clk outside reset.
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FPBA_ASSERT(lbl, prop, msg)
`define FPBA_ASSERT_IMPL(lbl, ante, cons, msg)
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/fpba_pkg.sv @@
`timescale 1ns / 1ps

package fpba_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	localparam int BC_W       = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [BC_W-1:0] BLOCK_COUNT_RESET = BC_W'(16);

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_policy_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIT_POLICY  = CFG_IDX_W'(0),
		CFG_BLOCK_COUNT = CFG_IDX_W'(1)
	} cfg_idx_t;

	typedef struct packed {
		op_t         operation;
		logic [3:0]  block_index;
		logic [15:0] amount;
	} item_t;

	typedef struct packed {
		logic        granted;
		logic [3:0]  chosen_block;
		logic [15:0] remaining_after;
	} result_t;

	// Search record handed from cell to cell.
	typedef struct packed {
		logic                 valid;
		logic [SIZE_BITS-1:0] amt;
		logic                 found;
		logic [IDX_W-1:0]     pick;
		logic [SIZE_BITS-1:0] best;
	} scan_t;

	// Capacity write broadcast to all cells.
	typedef struct packed {
		logic                 en;
		logic [IDX_W-1:0]     idx;
		logic [SIZE_BITS-1:0] data;
	} cell_wr_t;

endpackage

@@ hdl/fpba_cell.sv @@
`timescale 1ns / 1ps

module fpba_cell
	import fpba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IDX_W-1:0]     pos,
	input  fit_policy_t          policy,
	input  logic [BC_W-1:0]      count,
	input  cell_wr_t             wr,
	input  scan_t                scan_in,
	output scan_t                scan_out
);

	logic [SIZE_BITS-1:0] cap_q;
	scan_t                scan_q;
	logic                 in_use;
	logic                 fits;
	logic                 take;

	// Counts above the table size cover every cell anyway.
	assign in_use = 32'(pos) < 32'(count);
	assign fits   = scan_in.valid && in_use && (cap_q >= scan_in.amt);

	always_comb begin
		take = 1'b0;
		if (fits) begin
			if (!scan_in.found) begin
				take = 1'b1;
			end else begin
				case (policy)
					FIT_BEST:  take = cap_q < scan_in.best;
					FIT_WORST: take = cap_q > scan_in.best;
					default:   take = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (wr.en && (wr.idx == pos)) begin
			cap_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q.valid <= scan_in.valid;
			scan_q.amt   <= scan_in.amt;
			scan_q.found <= scan_in.found || fits;
			scan_q.pick  <= take ? pos : scan_in.pick;
			scan_q.best  <= take ? cap_q : scan_in.best;
		end
	end

	assign scan_out = scan_q;

endmodule

@@ hdl/fit_policy_block_allocator.sv @@
`timescale 1ns / 1ps
// Fit-policy block allocator.
// Items enter on item while start is high and busy is low. A load item writes
// one block's capacity; an allocate item searches the configured blocks and
// takes its request from the block picked by fit_policy (first, best or worst
// fit, ties to the lowest index).
// Each item yields one result on result, marked by done for exactly one cycle.
// Loads: result in the cycle after the transfer, busy stays low, so a load can
// follow in every cycle.
// Allocates: the request walks a row of MAX_BLOCKS cells, one cell per cycle,
// then the picked cell is written. busy rises with the transfer and falls as
// the result appears, so no new item is taken while a search is in flight;
// the length of the cell row sets how long a search takes.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 fit_policy,
// 1 block_count) and cfg_data; cfg_ready is always high. Write only while idle.
// Reset clears every capacity to zero, fit_policy to first fit and
// block_count to 16. The receiver cannot stall; done is never held.

`include "fit_policy_block_allocator_macros.svh"

module fit_policy_block_allocator
	import fpba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	fit_policy_t          fit_policy_q;
	logic [BC_W-1:0]      block_count_q;
	logic                 busy_q;
	logic                 done_q;
	result_t              result_q;

	logic                 accept;
	logic                 load_acc;
	logic                 alloc_acc;
	logic                 idx_ok;
	logic [SIZE_BITS-1:0] amt_sz;
	logic [SIZE_BITS-1:0] new_cap;
	scan_t                inject;
	scan_t                last;
	cell_wr_t             wr;
	scan_t                scan_o [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] scan_vld;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q  <= FIT_FIRST;
			block_count_q <= BLOCK_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FIT_POLICY:  fit_policy_q  <= fit_policy_t'(cfg_data[1:0]);
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[BC_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept    = start && !busy_q;
	assign load_acc  = accept && (item.operation == OP_LOAD);
	assign alloc_acc = accept && (item.operation == OP_ALLOC);
	assign amt_sz    = SIZE_BITS'(item.amount);
	assign idx_ok    = 32'(item.block_index) < MAX_BLOCKS;

	always_comb begin
		inject       = '0;
		inject.valid = alloc_acc;
		inject.amt   = amt_sz;
	end

	genvar g;
	generate
		for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
			scan_t cell_in;
			if (g == 0) begin : g_head
				assign cell_in = inject;
			end else begin : g_link
				assign cell_in = scan_o[g-1];
			end
			fpba_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.pos      (IDX_W'(g)),
				.policy   (fit_policy_q),
				.count    (block_count_q),
				.wr       (wr),
				.scan_in  (cell_in),
				.scan_out (scan_o[g])
			);
			assign scan_vld[g] = scan_o[g].valid;
		end
	endgenerate

	assign last    = scan_o[MAX_BLOCKS-1];
	assign new_cap = last.best - last.amt;

	// Loads and commits never meet: busy holds off new items during a search.
	always_comb begin
		wr = '0;
		if (load_acc) begin
			wr.en   = idx_ok;
			wr.idx  = IDX_W'(item.block_index);
			wr.data = amt_sz;
		end else if (last.valid && last.found) begin
			wr.en   = 1'b1;
			wr.idx  = last.pick;
			wr.data = new_cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (alloc_acc) begin
				busy_q <= 1'b1;
			end else if (last.valid) begin
				busy_q <= 1'b0;
			end
			done_q <= load_acc || last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_acc) begin
			result_q.granted         <= 1'b0;
			result_q.chosen_block    <= item.block_index;
			result_q.remaining_after <= idx_ok ? 16'(amt_sz) : '0;
		end else if (last.valid) begin
			result_q.granted         <= last.found;
			result_q.chosen_block    <= last.found ? 4'(last.pick) : '0;
			result_q.remaining_after <= last.found ? 16'(new_cap) : '0;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	`FPBA_ASSERT(a_one_search, $onehot0(scan_vld), "more than one search in the cell row")
	`FPBA_ASSERT_IMPL(a_busy_search, busy_q, $onehot(scan_vld), "busy without a search in flight")
	`FPBA_ASSERT_NEXT(a_alloc_busy, alloc_acc, busy_q && scan_vld[0], "allocate did not enter the row")
	`FPBA_ASSERT_NEXT(a_commit_done, last.valid, done_q && !busy_q, "search end gave no result")
	`FPBA_ASSERT_IMPL(a_idle_load, !busy_q, scan_vld == '0, "search in flight while idle")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench
	import fpba_pkg::*;
();

	localparam logic [1:0] FIT_SPARE    = 2'd3;
	localparam int         DRAIN_CYCLES = 24;
	localparam int         PHASES       = 12;
	localparam int         PHASE_ITEMS  = 152;

	class alloc_scoreboard;
		logic [1:0]           policy;
		logic [BC_W-1:0]      count;
		logic [SIZE_BITS-1:0] cap [MAX_BLOCKS];
		result_t              pending_results [$];
		int                   errors;

		function new();
			policy = FIT_FIRST;
			count  = BLOCK_COUNT_RESET;
			foreach (cap[i]) cap[i] = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_FIT_POLICY)
				policy = data[1:0];
			else if (idx == CFG_BLOCK_COUNT)
				count = data[BC_W-1:0];
		endfunction

		// Predict the grant for an accepted item and update the capacity table.
		function void note_item(item_t it);
			result_t r;
			int      n;
			logic    found;
			int      pick;
			r     = '0;
			found = 1'b0;
			pick  = 0;
			if (it.operation == OP_LOAD) begin
				cap[it.block_index] = it.amount;
				r.chosen_block      = it.block_index;
				r.remaining_after   = it.amount;
			end else begin
				n = (count > MAX_BLOCKS) ? MAX_BLOCKS : int'(count);
				for (int j = 0; j < n; j++) begin
					if (cap[j] >= it.amount) begin
						if (!found) begin
							found = 1'b1;
							pick  = j;
							// unused policy code behaves as first fit
							if (policy != FIT_BEST && policy != FIT_WORST)
								break;
						end else if (policy == FIT_BEST && cap[j] < cap[pick]) begin
							pick = j;
						end else if (policy == FIT_WORST && cap[j] > cap[pick]) begin
							pick = j;
						end
					end
				end
				if (found) begin
					cap[pick]         = cap[pick] - it.amount;
					r.granted         = 1'b1;
					r.chosen_block    = 4'(pick);
					r.remaining_after = cap[pick];
				end
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: granted %0d block %0d remaining %0d",
					got.granted, got.chosen_block, got.remaining_after);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.granted !== want.granted) begin
				$error("granted: expected %0d, got %0d", want.granted, got.granted);
				errors++;
			end
			if (got.chosen_block !== want.chosen_block) begin
				$error("chosen_block: expected %0d, got %0d", want.chosen_block,
					got.chosen_block);
				errors++;
			end
			if (got.remaining_after !== want.remaining_after) begin
				$error("remaining_after: expected %0d, got %0d", want.remaining_after,
					got.remaining_after);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	item_t                 item      = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  done;
	result_t               result;
	logic                  cfg_ready;

	alloc_scoreboard sb = new();

	logic [BC_W-1:0] phase_counts [PHASES] = '{
		5'd16, 5'd1, 5'd31, 5'd4, 5'd16, 5'd0, 5'd2, 5'd12, 5'd17, 5'd8, 5'd16, 5'd5
	};

	fit_policy_block_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	function automatic item_t mk(op_t op, logic [3:0] idx, logic [15:0] amt);
		item_t it;
		it.operation   = op;
		it.block_index = idx;
		it.amount      = amt;
		return it;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.block_index = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 99) < 40) begin
			it.operation = OP_LOAD;
			case ($urandom_range(0, 3))
				0: it.amount = 16'($urandom_range(0, 65535));
				1: it.amount = 16'($urandom_range(0, 15));
				2: it.amount = 16'hFFFF;
				default: it.amount = 16'($urandom_range(0, 1023));
			endcase
		end else begin
			it.operation = OP_ALLOC;
			case ($urandom_range(0, 5))
				0: it.amount = '0;
				1: it.amount = 16'($urandom_range(0, 65535));
				2: it.amount = 16'($urandom_range(0, 15));
				// exact fit, or one past it, against a current capacity
				3: it.amount = sb.cap[$urandom_range(0, 15)];
				4: it.amount = sb.cap[$urandom_range(0, 15)] + 16'd1;
				default: it.amount = 16'($urandom_range(0, 1023));
			endcase
		end
		return it;
	endfunction

	function automatic int draw_gap(int phase);
		if (phase % 3 == 0)
			return 0;
		return $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
	endfunction

	// Hold start high across back-to-back items; drop it only for a gap.
	task automatic send_item(item_t it, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		sb.note_item(it);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers in consecutive transfers with valid held high.
	task automatic set_config(logic [1:0] pol, logic [BC_W-1:0] cnt);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_FIT_POLICY;
		cfg_data  <= CFG_DATA_W'(pol);
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(CFG_FIT_POLICY, CFG_DATA_W'(pol));
		cfg_index <= CFG_BLOCK_COUNT;
		cfg_data  <= CFG_DATA_W'(cnt);
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(cnt));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: first fit over all blocks
		send_item(mk(OP_LOAD, 4'd0, 16'hFFFF), 0);
		send_item(mk(OP_LOAD, 4'd15, 16'h0000), 0);
		send_item(mk(OP_LOAD, 4'd7, 16'h8000), 0);
		send_item(mk(OP_LOAD, 4'd3, 16'h5555), 0);
		send_item(mk(OP_LOAD, 4'd11, 16'hAAAA), 0);
		send_item(mk(OP_ALLOC, 4'd15, 16'h0000), 0);
		send_item(mk(OP_ALLOC, 4'd0, 16'hFFFF), 0);
		send_item(mk(OP_ALLOC, 4'd0, 16'h8000), 0);
		send_item(mk(OP_ALLOC, 4'd0, 16'h0001), 0);
		send_item(mk(OP_ALLOC, 4'd0, 16'hFFFF), 0);
		send_item(mk(OP_LOAD, 4'd2, 16'd100), 0);
		send_item(mk(OP_LOAD, 4'd5, 16'd100), 0);
		send_item(mk(OP_LOAD, 4'd9, 16'd300), 0);
		send_item(mk(OP_LOAD, 4'd12, 16'd50), 0);

		set_config(FIT_BEST, 5'd16);
		send_item(mk(OP_ALLOC, 4'd0, 16'd60), 0);
		send_item(mk(OP_ALLOC, 4'd0, 16'd40), 0);
		set_config(FIT_WORST, 5'd16);
		send_item(mk(OP_ALLOC, 4'd0, 16'd10), 0);
		set_config(FIT_SPARE, 5'd16);
		send_item(mk(OP_ALLOC, 4'd0, 16'd10), 0);
		set_config(FIT_FIRST, 5'd0);
		send_item(mk(OP_ALLOC, 4'd0, 16'h0000), 0);
		set_config(FIT_WORST, 5'd31);
		send_item(mk(OP_ALLOC, 4'd0, 16'd290), 0);
		// block 12 lies outside the configured range here
		set_config(FIT_BEST, 5'd10);
		send_item(mk(OP_LOAD, 4'd12, 16'd5), 0);
		send_item(mk(OP_ALLOC, 4'd0, 16'd5), 0);

		for (int p = 0; p < PHASES; p++) begin
			set_config(2'(p % 4), phase_counts[p]);
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_item(rand_item(), draw_gap(p));
		end

		wait_idle();
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
